@@ rtl/core/tae_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tae_pkg;

   // Alarm state codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_LOW1  = 3'd1;
   localparam logic [2:0] ST_LOW2  = 3'd2;
   localparam logic [2:0] ST_HIGH1 = 3'd3;
   localparam logic [2:0] ST_HIGH2 = 3'd4;
   localparam logic [2:0] ST_EMERG = 3'd5;

   // Lock period codes
   localparam logic [3:0] LOCK_OK     = 4'd1;
   localparam logic [3:0] LOCK_FIRST  = 4'd15;
   localparam logic [3:0] LOCK_SECOND = 4'd10;
   localparam logic [3:0] LOCK_EMERG  = 4'd15;

   // Action bit codes: bit2 main heater, bit1 backup heater, bit0 alert
   localparam logic [2:0] ACT_OK         = 3'd4;
   localparam logic [2:0] ACT_LOW        = 3'd6;
   localparam logic [2:0] ACT_HIGH       = 3'd0;
   localparam logic [2:0] ACT_LOW_ALERT  = 3'd7;
   localparam logic [2:0] ACT_HIGH_ALERT = 3'd1;

   // Register indexes
   localparam logic [1:0] REG_MAX_LIMIT = 2'd0;
   localparam logic [1:0] REG_MIN_LIMIT = 2'd1;

   // Reset values of the limits
   localparam logic signed [7:0] MAX_LIMIT_RESET = 8'sd100;
   localparam logic signed [7:0] MIN_LIMIT_RESET = 8'sd0;

   // One result item
   typedef struct packed {
      logic [3:0]        lock_period;
      logic [2:0]        action_bits;
      logic [2:0]        alarm_state;
      logic signed [7:0] sample_echo;
   } tae_result_type;

   // Handshake between the input stage and the result stage
   typedef struct packed {
      logic valid;
      logic advance;
   } tae_stage_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/tae_input_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tae_input_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic signed [7:0] req_sample_temp,
   input  wire logic              out_free,
   output tae_pkg::tae_stage_ctrl_type ctrl,
   output logic signed [7:0]      sample
);

   logic              valid_ff;
   logic              valid_in;
   logic signed [7:0] sample_ff;
   logic              advance;
   logic              take;

   // Move the held sample on whenever the result register can take it
   assign advance   = valid_ff & out_free;
   assign req_ready = ~valid_ff | advance;
   assign take      = req_valid & req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the sample on each input transfer
   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff <= req_sample_temp;
      end
   end

   assign ctrl.valid   = valid_ff;
   assign ctrl.advance = advance;
   assign sample       = sample_ff;

endmodule

`default_nettype wire

@@ rtl/core/tae_alarm_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tae_alarm_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic signed [7:0] sample,
   input  wire logic signed [7:0] max_limit,
   input  wire logic signed [7:0] min_limit,
   output tae_pkg::tae_result_type result
);

   logic [2:0]        mode_ff;
   logic [2:0]        mode_in;
   logic signed [7:0] prev_ff;
   logic              low;
   logic              high;
   logic [3:0]        lock;
   logic [2:0]        act;

   assign low  = sample < min_limit;
   assign high = sample > max_limit;

   // Next alarm state and the codes that go with it
   always_comb begin
      mode_in = tae_pkg::ST_OK;
      lock    = tae_pkg::LOCK_OK;
      act     = tae_pkg::ACT_OK;
      unique case (mode_ff)
         tae_pkg::ST_LOW1: begin
            priority if (low) begin
               if (sample <= prev_ff) begin
                  mode_in = tae_pkg::ST_LOW2;
                  lock    = tae_pkg::LOCK_SECOND;
               end else begin
                  mode_in = tae_pkg::ST_LOW1;
                  lock    = tae_pkg::LOCK_FIRST;
               end
               act = tae_pkg::ACT_LOW;
            end else if (high) begin
               mode_in = tae_pkg::ST_HIGH1;
               lock    = tae_pkg::LOCK_FIRST;
               act     = tae_pkg::ACT_HIGH;
            end else begin
               // In range: keep the OK codes
            end
         end
         tae_pkg::ST_LOW2: begin
            priority if (low) begin
               mode_in = tae_pkg::ST_EMERG;
               lock    = tae_pkg::LOCK_EMERG;
               act     = tae_pkg::ACT_LOW_ALERT;
            end else if (high) begin
               mode_in = tae_pkg::ST_HIGH1;
               lock    = tae_pkg::LOCK_FIRST;
               act     = tae_pkg::ACT_HIGH;
            end else begin
               // In range: keep the OK codes
            end
         end
         tae_pkg::ST_HIGH1: begin
            priority if (low) begin
               mode_in = tae_pkg::ST_LOW1;
               lock    = tae_pkg::LOCK_FIRST;
               act     = tae_pkg::ACT_LOW;
            end else if (high) begin
               if (sample >= prev_ff) begin
                  mode_in = tae_pkg::ST_HIGH2;
                  lock    = tae_pkg::LOCK_SECOND;
               end else begin
                  mode_in = tae_pkg::ST_HIGH1;
                  lock    = tae_pkg::LOCK_FIRST;
               end
               act = tae_pkg::ACT_HIGH;
            end else begin
               // In range: keep the OK codes
            end
         end
         tae_pkg::ST_HIGH2: begin
            // High is tested first here
            priority if (high) begin
               mode_in = tae_pkg::ST_EMERG;
               lock    = tae_pkg::LOCK_EMERG;
               act     = tae_pkg::ACT_HIGH_ALERT;
            end else if (low) begin
               mode_in = tae_pkg::ST_LOW1;
               lock    = tae_pkg::LOCK_FIRST;
               act     = tae_pkg::ACT_LOW;
            end else begin
               // In range: keep the OK codes
            end
         end
         tae_pkg::ST_EMERG: begin
            priority if (high) begin
               mode_in = tae_pkg::ST_EMERG;
               lock    = tae_pkg::LOCK_EMERG;
               act     = tae_pkg::ACT_HIGH_ALERT;
            end else if (low) begin
               mode_in = tae_pkg::ST_EMERG;
               lock    = tae_pkg::LOCK_EMERG;
               act     = tae_pkg::ACT_LOW_ALERT;
            end else begin
               // In range: keep the OK codes
            end
         end
         default: begin
            // OK, and the unreachable codes behave the same
            priority if (low) begin
               mode_in = tae_pkg::ST_LOW1;
               lock    = tae_pkg::LOCK_FIRST;
               act     = tae_pkg::ACT_LOW;
            end else if (high) begin
               mode_in = tae_pkg::ST_HIGH1;
               lock    = tae_pkg::LOCK_FIRST;
               act     = tae_pkg::ACT_HIGH;
            end else begin
               // In range: keep the OK codes
            end
         end
      endcase
   end

   // Advance the state and remember the sample once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tae_pkg::ST_OK;
         prev_ff <= 8'sd0;
      end else if (step) begin
         mode_ff <= mode_in;
         prev_ff <= sample;
      end
   end

   assign result.lock_period = lock;
   assign result.action_bits = act;
   assign result.alarm_state = mode_in;
   assign result.sample_echo = sample;

endmodule

`default_nettype wire

@@ rtl/core/temperature_alarm_escalation_unit.sv @@
`timescale 1ns / 1ps
// Flow: an accepted sample waits in the input register and moves into the
// result register, onto the outputs, once that register is free; it then
// transfers when the receiver is ready. Throughput: one sample per cycle
// while rsp_ready is high; input and result registers form a two-stage
// pipeline, with one compare-and-select step for the alarm state between.
// Reset: synchronous, clears both stages, sets the state to OK, the stored
// sample to zero and the limits to 100 (max) and 0 (min).
`default_nettype none

module temperature_alarm_escalation_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic signed [7:0] req_sample_temp,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [3:0]             rsp_lock_period,
   output logic [2:0]             rsp_action_bits,
   output logic [2:0]             rsp_alarm_state,
   output logic signed [7:0]      rsp_sample_echo,
   input  wire logic              csr_wr_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_wdata
);

   logic signed [7:0]           max_limit_ff;
   logic signed [7:0]           min_limit_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   tae_pkg::tae_result_type     result_ff;
   tae_pkg::tae_result_type     result_in;
   tae_pkg::tae_stage_ctrl_type in_ctrl;
   logic signed [7:0]           stage_sample;
   logic                        out_free;

   // Limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_limit_ff <= tae_pkg::MAX_LIMIT_RESET;
         min_limit_ff <= tae_pkg::MIN_LIMIT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == tae_pkg::REG_MAX_LIMIT) begin
            max_limit_ff <= csr_wdata;
         end
         if (csr_index == tae_pkg::REG_MIN_LIMIT) begin
            min_limit_ff <= csr_wdata;
         end
      end
   end

   // Result register is free when empty or draining this cycle
   assign out_free = ~rsp_valid_ff | rsp_ready;

   tae_input_stage u_input (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_temp (req_sample_temp),
      .out_free        (out_free),
      .ctrl            (in_ctrl),
      .sample          (stage_sample)
   );

   tae_alarm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (in_ctrl.advance),
      .sample    (stage_sample),
      .max_limit (max_limit_ff),
      .min_limit (min_limit_ff),
      .result    (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (in_ctrl.advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result whenever a sample moves out of the input stage
   always_ff @(posedge clock) begin
      if (in_ctrl.valid && out_free) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lock_period = result_ff.lock_period;
   assign rsp_action_bits = result_ff.action_bits;
   assign rsp_alarm_state = result_ff.alarm_state;
   assign rsp_sample_echo = result_ff.sample_echo;

endmodule

`default_nettype wire
